// File: hw/rtl/rbnh_pkg.sv
// ----------------------------------------------------------------------------
// rbnh_pkg
// Shared types and constants for the ray / box nearest-hit block.
// ----------------------------------------------------------------------------
`default_nettype none

package rbnh_pkg;

    localparam int MAX_BOXES_DEF = 1024;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int INDEX_W       = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RAY_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAY_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAY_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAY_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAY_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAY_DIR_Z    = 3'd5;

    localparam logic signed [31:0] DIR_Z_RESET = 32'sd65536;

    typedef struct packed {
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
        logic               last_box;
    } t_box;

    typedef struct packed {
        logic                 hit_found;
        logic [INDEX_W-1:0]   nearest_index;
        logic signed [31:0]   nearest_distance;
    } t_hit;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_SQ,
        OP_ACC_SUM,
        OP_SQRT_GO,
        OP_NDIV_GO,
        OP_NDIV_STORE,
        OP_MUL_UV,
        OP_ACC_T,
        OP_TQ,
        OP_MUL_UTQ,
        OP_P_RND,
        OP_E_CALC,
        OP_MUL_EE,
        OP_ACC_E,
        OP_H_CALC,
        OP_ACC_H,
        OP_E_CHECK,
        OP_Z_CHECK,
        OP_SDIV_GO,
        OP_SDIV_STORE,
        OP_UPDATE,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] ax;
        logic       side;
    } t_cmd;

    typedef struct packed {
        logic       run_open;
        logic       hit;
        logic       t_neg;
        logic [2:0] unit_zero;
        logic       sqrt_busy;
        logic       div_busy;
        logic       out_full;
        logic       last;
    } t_sts;

endpackage

`default_nettype wire

// File: hw/rtl/rbnh_ctrl.sv
// ----------------------------------------------------------------------------
// rbnh_ctrl
// Sequencer: walks one box through normalization (first box of a run only), prefilter and slab test.
// ----------------------------------------------------------------------------
`default_nettype none

module rbnh_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_box_valid,
    input  wire rbnh_pkg::t_sts i_sts,
    output rbnh_pkg::t_cmd     o_cmd,
    output logic               o_box_stall
);

    typedef enum logic [22:0] {
        S_IDLE      = 23'b1 << 0,
        S_NSQ_MUL   = 23'b1 << 1,
        S_NSQ_ACC   = 23'b1 << 2,
        S_SQRT_GO   = 23'b1 << 3,
        S_SQRT_WAIT = 23'b1 << 4,
        S_NDIV_GO   = 23'b1 << 5,
        S_NDIV_WAIT = 23'b1 << 6,
        S_DOT_MUL   = 23'b1 << 7,
        S_DOT_ACC   = 23'b1 << 8,
        S_TQ        = 23'b1 << 9,
        S_PMUL      = 23'b1 << 10,
        S_PRND      = 23'b1 << 11,
        S_PERR      = 23'b1 << 12,
        S_EMUL      = 23'b1 << 13,
        S_EACC      = 23'b1 << 14,
        S_HPREP     = 23'b1 << 15,
        S_HMUL      = 23'b1 << 16,
        S_HACC      = 23'b1 << 17,
        S_ECHK      = 23'b1 << 18,
        S_SLAB_GO   = 23'b1 << 19,
        S_SLAB_WAIT = 23'b1 << 20,
        S_FINISH    = 23'b1 << 21,
        S_EMIT      = 23'b1 << 22
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_ax, n_ax;
    logic       r_side, n_side;

    always_comb begin
        n_state    = r_state;
        n_ax       = r_ax;
        n_side     = r_side;
        o_cmd.op   = rbnh_pkg::OP_NONE;
        o_cmd.ax   = r_ax;
        o_cmd.side = r_side;
        unique case (r_state)
            S_IDLE: begin
                if (i_box_valid) begin
                    o_cmd.op = rbnh_pkg::OP_LOAD;
                    n_ax     = 2'd0;
                    n_side   = 1'b0;
                    n_state  = i_sts.run_open ? S_DOT_MUL : S_NSQ_MUL;
                end
            end
            S_NSQ_MUL: begin
                o_cmd.op = rbnh_pkg::OP_MUL_SQ;
                n_state  = S_NSQ_ACC;
            end
            S_NSQ_ACC: begin
                o_cmd.op = rbnh_pkg::OP_ACC_SUM;
                if (r_ax == 2'd2) begin
                    n_ax    = 2'd0;
                    n_state = S_SQRT_GO;
                end else begin
                    n_ax    = r_ax + 2'd1;
                    n_state = S_NSQ_MUL;
                end
            end
            S_SQRT_GO: begin
                o_cmd.op = rbnh_pkg::OP_SQRT_GO;
                n_state  = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
                if (!i_sts.sqrt_busy) n_state = S_NDIV_GO;
            end
            S_NDIV_GO: begin
                o_cmd.op = rbnh_pkg::OP_NDIV_GO;
                n_state  = S_NDIV_WAIT;
            end
            S_NDIV_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = rbnh_pkg::OP_NDIV_STORE;
                    if (r_ax == 2'd2) begin
                        n_ax    = 2'd0;
                        n_state = S_DOT_MUL;
                    end else begin
                        n_ax    = r_ax + 2'd1;
                        n_state = S_NDIV_GO;
                    end
                end
            end
            S_DOT_MUL: begin
                o_cmd.op = rbnh_pkg::OP_MUL_UV;
                n_state  = S_DOT_ACC;
            end
            S_DOT_ACC: begin
                o_cmd.op = rbnh_pkg::OP_ACC_T;
                if (r_ax == 2'd2) begin
                    n_ax    = 2'd0;
                    n_state = S_TQ;
                end else begin
                    n_ax    = r_ax + 2'd1;
                    n_state = S_DOT_MUL;
                end
            end
            S_TQ: begin
                o_cmd.op = rbnh_pkg::OP_TQ;
                n_state  = i_sts.t_neg ? S_FINISH : S_PMUL;
            end
            S_PMUL: begin
                o_cmd.op = rbnh_pkg::OP_MUL_UTQ;
                n_state  = S_PRND;
            end
            S_PRND: begin
                o_cmd.op = rbnh_pkg::OP_P_RND;
                n_state  = S_PERR;
            end
            S_PERR: begin
                o_cmd.op = rbnh_pkg::OP_E_CALC;
                n_state  = S_EMUL;
            end
            S_EMUL: begin
                o_cmd.op = rbnh_pkg::OP_MUL_EE;
                n_state  = S_EACC;
            end
            S_EACC: begin
                o_cmd.op = rbnh_pkg::OP_ACC_E;
                n_state  = S_HPREP;
            end
            S_HPREP: begin
                o_cmd.op = rbnh_pkg::OP_H_CALC;
                n_state  = S_HMUL;
            end
            S_HMUL: begin
                o_cmd.op = rbnh_pkg::OP_MUL_EE;
                n_state  = S_HACC;
            end
            S_HACC: begin
                o_cmd.op = rbnh_pkg::OP_ACC_H;
                if (r_ax == 2'd2) begin
                    n_ax    = 2'd0;
                    n_state = S_ECHK;
                end else begin
                    n_ax    = r_ax + 2'd1;
                    n_state = S_PMUL;
                end
            end
            S_ECHK: begin
                o_cmd.op = rbnh_pkg::OP_E_CHECK;
                n_side   = 1'b0;
                n_state  = S_SLAB_GO;
            end
            S_SLAB_GO: begin
                if (!i_sts.hit) begin
                    n_state = S_FINISH;
                end else if (i_sts.unit_zero[r_ax]) begin
                    o_cmd.op = rbnh_pkg::OP_Z_CHECK;
                    if (r_ax == 2'd2) begin
                        n_state = S_FINISH;
                    end else begin
                        n_ax = r_ax + 2'd1;
                    end
                end else begin
                    o_cmd.op = rbnh_pkg::OP_SDIV_GO;
                    n_state  = S_SLAB_WAIT;
                end
            end
            S_SLAB_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = rbnh_pkg::OP_SDIV_STORE;
                    if (!r_side) begin
                        n_side  = 1'b1;
                        n_state = S_SLAB_GO;
                    end else begin
                        n_side = 1'b0;
                        if (r_ax == 2'd2) begin
                            n_state = S_FINISH;
                        end else begin
                            n_ax    = r_ax + 2'd1;
                            n_state = S_SLAB_GO;
                        end
                    end
                end
            end
            S_FINISH: begin
                o_cmd.op = rbnh_pkg::OP_UPDATE;
                n_state  = i_sts.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (!i_sts.out_full) begin
                    o_cmd.op = rbnh_pkg::OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ax    <= 2'd0;
            r_side  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ax    <= n_ax;
            r_side  <= n_side;
        end
    end

    assign o_box_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// File: hw/rtl/rbnh_dp.sv
// ----------------------------------------------------------------------------
// rbnh_dp
// Datapath: ray registers, shared multiplier, square root and divider units,
// accumulators, run tracking and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbnh_dp #(
    parameter int MAX_BOXES = rbnh_pkg::MAX_BOXES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [rbnh_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [rbnh_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire rbnh_pkg::t_box                      i_box,
    input  wire rbnh_pkg::t_cmd                      i_cmd,
    input  wire logic                                i_hit_stall,
    output rbnh_pkg::t_sts                           o_sts,
    output logic                                     o_hit_valid,
    output rbnh_pkg::t_hit                           o_hit
);

    localparam int CNT_W = $clog2(MAX_BOXES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_BOXES - 1);
    localparam int DIV_N = 49;
    localparam logic [5:0] DIV_LAST = 6'(DIV_N - 1);

    // ray and box
    logic signed [31:0] r_org  [3];
    logic signed [31:0] r_dir  [3];
    logic signed [17:0] r_unit [3];
    logic signed [31:0] r_lo   [3];
    logic signed [31:0] r_hi   [3];
    logic               r_last;

    // arithmetic
    logic signed [71:0] r_prod;
    logic [63:0]        r_sum;
    logic signed [55:0] r_t;
    logic signed [38:0] r_tq;
    logic signed [39:0] r_p;
    logic [31:0]        r_e;
    logic [63:0]        r_esq, r_hsq;
    logic signed [50:0] r_near, r_far, r_t1;
    logic               r_hit;

    // square root unit
    logic [63:0] r_sq_x, r_sq_r, r_sq_bit;
    logic [4:0]  r_sq_cnt;
    logic        r_sq_busy;

    // divider unit
    logic [48:0] r_dv_num;
    logic [31:0] r_dv_rem, r_dv_den;
    logic [5:0]  r_dv_cnt;
    logic        r_dv_busy, r_dv_neg;

    // run tracking
    logic signed [31:0] r_best;
    logic [rbnh_pkg::INDEX_W-1:0] r_best_idx;
    logic               r_any;
    logic [CNT_W-1:0]   r_count;
    logic               r_run_open;
    logic               r_out_valid;
    rbnh_pkg::t_hit     r_out;

    function automatic logic signed [39:0] rnd16(input logic signed [55:0] x);
        logic [55:0] m;
        logic [55:0] q;
        m = x[55] ? 56'(-x) : 56'(x);
        q = (m + 56'd32768) >> 16;
        return x[55] ? -$signed(40'(q)) : $signed(40'(q));
    endfunction

    function automatic logic [31:0] rnd5mag(input logic signed [41:0] x);
        logic [41:0] m;
        logic [41:0] q;
        m = x[41] ? 42'(-x) : 42'(x);
        q = (m + 42'd16) >> 5;
        return q[31:0];
    endfunction

    // per-axis selection
    logic signed [31:0] c_lo, c_hi, c_org, c_dir, c_a, c_b, c_bound;
    logic signed [17:0] c_unit;
    logic signed [34:0] c_v;
    logic [31:0]        c_dmag;
    logic [16:0]        c_umag;
    logic signed [32:0] c_num;
    logic [32:0]        c_nmag;
    logic signed [33:0] c_hd;
    logic signed [41:0] c_ediff;
    logic [31:0]        c_len;

    assign c_lo    = r_lo[i_cmd.ax];
    assign c_hi    = r_hi[i_cmd.ax];
    assign c_org   = r_org[i_cmd.ax];
    assign c_dir   = r_dir[i_cmd.ax];
    assign c_unit  = r_unit[i_cmd.ax];
    assign c_v     = 35'(c_lo) + 35'(c_hi) - (35'(c_org) <<< 1);
    assign c_dmag  = c_dir[31] ? (~c_dir + 32'd1) : c_dir;
    assign c_umag  = c_unit[17] ? 17'(~c_unit + 18'sd1) : 17'(c_unit);
    assign c_a     = (c_lo < c_hi) ? c_lo : c_hi;
    assign c_b     = (c_lo < c_hi) ? c_hi : c_lo;
    assign c_bound = i_cmd.side ? c_b : c_a;
    assign c_num   = 33'(c_bound) - 33'(c_org);
    assign c_nmag  = c_num[32] ? 33'(-c_num) : 33'(c_num);
    assign c_hd    = 34'(c_hi) - 34'(c_lo);
    assign c_ediff = 42'(r_p) - 42'(c_v);
    assign c_len   = r_sq_r[31:0];

    // shared multiplier operands
    logic signed [32:0] c_ma;
    logic signed [38:0] c_mb;

    always_comb begin
        c_ma = '0;
        c_mb = '0;
        unique case (i_cmd.op)
            rbnh_pkg::OP_MUL_SQ: begin
                c_ma = $signed({1'b0, c_dmag});
                c_mb = $signed({7'b0, c_dmag});
            end
            rbnh_pkg::OP_MUL_UV: begin
                c_ma = 33'(c_unit);
                c_mb = 39'(c_v);
            end
            rbnh_pkg::OP_MUL_UTQ: begin
                c_ma = 33'(c_unit);
                c_mb = r_tq;
            end
            rbnh_pkg::OP_MUL_EE: begin
                c_ma = $signed({1'b0, r_e});
                c_mb = $signed({7'b0, r_e});
            end
            default: begin
                c_ma = '0;
                c_mb = '0;
            end
        endcase
    end

    // square root step
    logic [63:0] c_sq_try;
    assign c_sq_try = r_sq_r + r_sq_bit;

    // divider step
    logic [32:0] c_dv_sh;
    logic        c_dv_ge;
    assign c_dv_sh = {r_dv_rem, r_dv_num[48]};
    assign c_dv_ge = (c_dv_sh >= {1'b0, r_dv_den});

    // slab quotient and outcome
    logic signed [50:0] c_q, c_tn, c_tf;
    logic signed [31:0] c_dsat;
    logic               c_good;

    assign c_q  = r_dv_neg ? -$signed({2'b0, r_dv_num}) : $signed({2'b0, r_dv_num});
    assign c_tn = (r_t1 < c_q) ? r_t1 : c_q;
    assign c_tf = (r_t1 < c_q) ? c_q : r_t1;
    assign c_dsat = (r_near > 51'sd2147483647)  ? 32'sh7FFFFFFF :
                    (r_near < -51'sd2147483648) ? 32'sh80000000 : 32'(r_near);
    assign c_good = r_hit && (r_near <= r_far) && (r_far > 51'sd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0]    <= '0;
            r_org[1]    <= '0;
            r_org[2]    <= '0;
            r_dir[0]    <= '0;
            r_dir[1]    <= '0;
            r_dir[2]    <= rbnh_pkg::DIR_Z_RESET;
            r_unit[0]   <= '0;
            r_unit[1]   <= '0;
            r_unit[2]   <= '0;
            r_best      <= 32'sh7FFFFFFF;
            r_best_idx  <= '0;
            r_any       <= 1'b0;
            r_count     <= '0;
            r_run_open  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sq_busy   <= 1'b0;
            r_dv_busy   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rbnh_pkg::CFG_RAY_ORIGIN_X: r_org[0] <= i_cfg_data;
                    rbnh_pkg::CFG_RAY_ORIGIN_Y: r_org[1] <= i_cfg_data;
                    rbnh_pkg::CFG_RAY_ORIGIN_Z: r_org[2] <= i_cfg_data;
                    rbnh_pkg::CFG_RAY_DIR_X:    r_dir[0] <= i_cfg_data;
                    rbnh_pkg::CFG_RAY_DIR_Y:    r_dir[1] <= i_cfg_data;
                    rbnh_pkg::CFG_RAY_DIR_Z:    r_dir[2] <= i_cfg_data;
                    default: ;
                endcase
            end

            // a new result may replace one that leaves at this edge
            if (i_cmd.op == rbnh_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_hit_stall) begin
                r_out_valid <= 1'b0;
            end

            // isqrt, one result bit per cycle
            if (r_sq_busy) begin
                if (r_sq_x >= c_sq_try) begin
                    r_sq_x <= r_sq_x - c_sq_try;
                    r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
                end else begin
                    r_sq_r <= r_sq_r >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
                r_sq_cnt <= r_sq_cnt + 5'd1;
                if (r_sq_cnt == 5'd31) r_sq_busy <= 1'b0;
            end

            // restoring divider, one quotient bit per cycle
            if (r_dv_busy) begin
                r_dv_rem <= c_dv_ge ? 32'(c_dv_sh - {1'b0, r_dv_den}) : c_dv_sh[31:0];
                r_dv_num <= {r_dv_num[47:0], c_dv_ge};
                r_dv_cnt <= r_dv_cnt + 6'd1;
                if (r_dv_cnt == DIV_LAST) r_dv_busy <= 1'b0;
            end

            unique case (i_cmd.op)
                rbnh_pkg::OP_LOAD: begin
                    r_lo[0]    <= i_box.box_min_x;
                    r_lo[1]    <= i_box.box_min_y;
                    r_lo[2]    <= i_box.box_min_z;
                    r_hi[0]    <= i_box.box_max_x;
                    r_hi[1]    <= i_box.box_max_y;
                    r_hi[2]    <= i_box.box_max_z;
                    r_last     <= i_box.last_box;
                    r_hit      <= 1'b1;
                    r_near     <= {1'b1, 50'b0};
                    r_far      <= {1'b0, {50{1'b1}}};
                    r_sum      <= '0;
                    r_t        <= '0;
                    r_esq      <= '0;
                    r_hsq      <= '0;
                    r_run_open <= 1'b1;
                end
                rbnh_pkg::OP_MUL_SQ,
                rbnh_pkg::OP_MUL_UV,
                rbnh_pkg::OP_MUL_UTQ,
                rbnh_pkg::OP_MUL_EE: r_prod <= c_ma * c_mb;
                rbnh_pkg::OP_ACC_SUM: r_sum <= r_sum + r_prod[63:0];
                rbnh_pkg::OP_SQRT_GO: begin
                    r_sq_x    <= r_sum;
                    r_sq_r    <= '0;
                    r_sq_bit  <= 64'd1 << 62;
                    r_sq_cnt  <= '0;
                    r_sq_busy <= 1'b1;
                end
                rbnh_pkg::OP_NDIV_GO: begin
                    r_dv_num  <= 49'({c_dmag, 16'b0}) + 49'(c_len >> 1);
                    r_dv_den  <= c_len;
                    r_dv_rem  <= '0;
                    r_dv_cnt  <= '0;
                    r_dv_busy <= 1'b1;
                end
                rbnh_pkg::OP_NDIV_STORE: begin
                    if (c_len == 32'd0) begin
                        r_unit[i_cmd.ax] <= '0;
                    end else if (c_dir[31]) begin
                        r_unit[i_cmd.ax] <= -$signed({1'b0, r_dv_num[16:0]});
                    end else begin
                        r_unit[i_cmd.ax] <= $signed({1'b0, r_dv_num[16:0]});
                    end
                end
                rbnh_pkg::OP_ACC_T: r_t <= r_t + $signed(r_prod[55:0]);
                rbnh_pkg::OP_TQ: begin
                    r_tq <= 39'(rnd16(r_t));
                    if (r_t[55]) r_hit <= 1'b0;
                end
                rbnh_pkg::OP_P_RND:  r_p <= rnd16($signed(r_prod[55:0]));
                rbnh_pkg::OP_E_CALC: r_e <= rnd5mag(c_ediff);
                rbnh_pkg::OP_ACC_E:  r_esq <= r_esq + r_prod[63:0];
                rbnh_pkg::OP_H_CALC: r_e <= rnd5mag(42'(c_hd));
                rbnh_pkg::OP_ACC_H:  r_hsq <= r_hsq + r_prod[63:0];
                rbnh_pkg::OP_E_CHECK: begin
                    if (r_esq > r_hsq) r_hit <= 1'b0;
                end
                rbnh_pkg::OP_Z_CHECK: begin
                    if (c_org < c_a || c_org > c_b) r_hit <= 1'b0;
                end
                rbnh_pkg::OP_SDIV_GO: begin
                    r_dv_num  <= 49'({c_nmag, 16'b0});
                    r_dv_den  <= 32'(c_umag);
                    r_dv_neg  <= c_num[32] ^ c_unit[17];
                    r_dv_rem  <= '0;
                    r_dv_cnt  <= '0;
                    r_dv_busy <= 1'b1;
                end
                rbnh_pkg::OP_SDIV_STORE: begin
                    if (!i_cmd.side) begin
                        r_t1 <= c_q;
                    end else begin
                        if (c_tn > r_near) r_near <= c_tn;
                        if (c_tf < r_far)  r_far  <= c_tf;
                    end
                end
                rbnh_pkg::OP_UPDATE: begin
                    if (c_good && (!r_any || c_dsat < r_best)) begin
                        r_best     <= c_dsat;
                        r_best_idx <= rbnh_pkg::INDEX_W'(r_count);
                        r_any      <= 1'b1;
                    end
                    r_count <= (r_count == CNT_LAST) ? '0 : r_count + 1'b1;
                end
                rbnh_pkg::OP_EMIT: begin
                    r_out.hit_found        <= r_any;
                    r_out.nearest_index    <= r_any ? r_best_idx : '0;
                    r_out.nearest_distance <= r_any ? r_best : 32'sd0;
                    r_best                 <= 32'sh7FFFFFFF;
                    r_best_idx             <= '0;
                    r_any                  <= 1'b0;
                    r_count                <= '0;
                    r_run_open             <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_sts.run_open     = r_run_open;
    assign o_sts.hit          = r_hit;
    assign o_sts.t_neg        = r_t[55];
    assign o_sts.unit_zero[0] = (r_unit[0] == 18'sd0);
    assign o_sts.unit_zero[1] = (r_unit[1] == 18'sd0);
    assign o_sts.unit_zero[2] = (r_unit[2] == 18'sd0);
    assign o_sts.sqrt_busy    = r_sq_busy;
    assign o_sts.div_busy     = r_dv_busy;
    assign o_sts.out_full     = r_out_valid && i_hit_stall;
    assign o_sts.last         = r_last;

    assign o_hit_valid = r_out_valid;
    assign o_hit       = r_out;

endmodule

`default_nettype wire

// File: hw/rtl/ray_box_nearest_hit.sv
// ----------------------------------------------------------------------------
// ray_box_nearest_hit
// Nearest hit of a configured ray against a run of axis-aligned Q16.16 boxes:
// bounding-sphere prefilter, slab test, nearest-hit tracking per run.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                 payload
//   box       in         i_box_valid / o_box_stall   rbnh_pkg::t_box
//   hit       out        o_hit_valid / i_hit_stall   rbnh_pkg::t_hit
//   config    in         i_cfg_we                    i_cfg_index, i_cfg_data
//
// One box at a time. A box stops early when its center lies behind the ray or
// the sphere test rejects it; else it reaches the slab test, where each bound
// on an axis with nonzero direction takes one pass of the 49-step shared
// divider. The first box of a run adds direction normalization (32-step square
// root, three divisions); a closing box adds a step that emits the result.
// Reset is synchronous and active low; the ray returns to origin 0, dir +z.
// A closing box waits for the result register if a previous result is stalled;
// a held result never blocks the configuration port.
//
`default_nettype none

module ray_box_nearest_hit #(
    parameter int MAX_BOXES = rbnh_pkg::MAX_BOXES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration writes
    input  wire logic                            i_cfg_we,
    input  wire logic [rbnh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rbnh_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // box transactions
    input  wire logic                            i_box_valid,
    output logic                                 o_box_stall,
    input  wire rbnh_pkg::t_box                  i_box,
    // result transactions
    output logic                                 o_hit_valid,
    input  wire logic                            i_hit_stall,
    output rbnh_pkg::t_hit                       o_hit
);

    rbnh_pkg::t_cmd w_cmd;   // sequencer -> datapath
    rbnh_pkg::t_sts w_sts;   // datapath -> sequencer

    // sequencer: owns the box handshake and the step order
    rbnh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_box_valid (i_box_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_box_stall (o_box_stall)
    );

    // datapath: ray state, arithmetic units, best-hit tracking, result register
    rbnh_dp #(
        .MAX_BOXES (MAX_BOXES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_box       (i_box),
        .i_cmd       (w_cmd),
        .i_hit_stall (i_hit_stall),
        .o_sts       (w_sts),
        .o_hit_valid (o_hit_valid),
        .o_hit       (o_hit)
    );

endmodule

`default_nettype wire
